@@ hdl/pfde_pkg.sv @@
// ----------------------------------------------------------------------------
// Page framebuffer draw engine package
// Shared types and constants: request codes, decoded commands and the
// sequencer states of the back end.
// ----------------------------------------------------------------------------
package pfde_pkg;

   // Request codes on req_type.
   localparam logic [2:0] REQ_PIXEL   = 3'd0;
   localparam logic [2:0] REQ_FILL    = 3'd1;
   localparam logic [2:0] REQ_OUTLINE = 3'd2;
   localparam logic [2:0] REQ_SCREEN  = 3'd3;
   localparam logic [2:0] REQ_READ    = 3'd4;

   localparam int X_W        = 7;
   localparam int Y_W        = 6;
   localparam int PAGE_W     = 3;   // y / 8
   localparam int BIT_W      = 3;   // y mod 8
   localparam int OFFSET_W   = 2;
   localparam int COL_SUM_W  = 9;   // x plus offset, compared against up to 511 columns
   localparam int PAGE_CMP_W = 5;   // page compared against up to 31 pages
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 2'd2;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_RECT,
      OP_OUTLINE,
      OP_SCREEN,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [X_W-1:0]  x0;
      logic [X_W-1:0]  x1;
      logic [Y_W-1:0]  y0;
      logic [Y_W-1:0]  y1;
      logic            white;
   } cmd_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RECT,
      S_FILL,
      S_READ,
      S_DONE
   } state_type;

   typedef struct packed {
      logic clearing;
   } back_stat_type;

endpackage

@@ hdl/pfde_front.sv @@
// ----------------------------------------------------------------------------
// Front end
// Accepts requests, sorts rectangle corners and turns each request into a
// command word for the queue.
// ----------------------------------------------------------------------------
module pfde_front (
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_type,
   input  logic [6:0]            req_x_first,
   input  logic [5:0]            req_y_first,
   input  logic [6:0]            req_x_second,
   input  logic [5:0]            req_y_second,
   input  logic                  req_colour,
   input  logic                  queue_full,
   input  pfde_pkg::back_stat_type back_stat,
   output logic                  push,
   output pfde_pkg::cmd_type     cmd
);
   import pfde_pkg::*;

   logic [X_W-1:0] x_lo, x_hi;
   logic [Y_W-1:0] y_lo, y_hi;

   assign busy = queue_full | back_stat.clearing;
   assign push = start & ~busy;

   assign x_lo = (req_x_first < req_x_second) ? req_x_first  : req_x_second;
   assign x_hi = (req_x_first < req_x_second) ? req_x_second : req_x_first;
   assign y_lo = (req_y_first < req_y_second) ? req_y_first  : req_y_second;
   assign y_hi = (req_y_first < req_y_second) ? req_y_second : req_y_first;

   always_comb begin
      cmd.white = req_colour;
      cmd.x0    = req_x_first;
      cmd.x1    = req_x_first;
      cmd.y0    = req_y_first;
      cmd.y1    = req_y_first;
      unique case (req_type)
         REQ_PIXEL: begin
            // A single pixel is a one by one filled rectangle.
            cmd.op = OP_RECT;
         end
         REQ_FILL: begin
            cmd.op = OP_RECT;
            cmd.x0 = x_lo;
            cmd.x1 = x_hi;
            cmd.y0 = y_lo;
            cmd.y1 = y_hi;
         end
         REQ_OUTLINE: begin
            cmd.op = OP_OUTLINE;
            cmd.x0 = x_lo;
            cmd.x1 = x_hi;
            cmd.y0 = y_lo;
            cmd.y1 = y_hi;
         end
         REQ_SCREEN: cmd.op = OP_SCREEN;
         REQ_READ:   cmd.op = OP_READ;
         default:    cmd.op = OP_NOP;
      endcase
   end

endmodule

@@ hdl/pfde_queue.sv @@
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer of command words between front and back.
// ----------------------------------------------------------------------------
module pfde_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pfde_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output pfde_pkg::cmd_type head
);
   import pfde_pkg::*;

   localparam int QW = $clog2(QUEUE_DEPTH);

   cmd_type       entry_ff [QUEUE_DEPTH];
   logic [QW-1:0] wptr_ff, wptr_in;
   logic [QW-1:0] rptr_ff, rptr_in;
   logic [QW:0]   count_ff, count_in;

   assign full      = (count_ff == (QW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == QW'(QUEUE_DEPTH-1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == QW'(QUEUE_DEPTH-1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/pfde_back.sv @@
// ----------------------------------------------------------------------------
// Back end
// Sequencer that owns the frame store and carries out one command at a
// time: byte-wise read-modify-write sweeps, whole-store fills and reads.
// ----------------------------------------------------------------------------
module pfde_back #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              column_offset,
   input  logic                    cmd_valid,
   input  pfde_pkg::cmd_type       cmd_head,
   output logic                    cmd_pop,
   output pfde_pkg::back_stat_type back_stat,
   output logic                    rsp_valid,
   output logic [7:0]              rsp_read_byte,
   output logic                    rsp_status
);
   import pfde_pkg::*;

   localparam int DEPTH = COLUMNS * PAGES;
   localparam int AW    = $clog2(DEPTH);

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [X_W-1:0]      cur_x_ff, cur_x_in;
   logic [PAGE_W-1:0]   cur_p_ff, cur_p_in;
   logic [AW-1:0]       fill_addr_ff, fill_addr_in;
   logic                wr_pend_ff, wr_pend_in;
   logic [AW-1:0]       wr_addr_ff, wr_addr_in;
   logic [7:0]          wr_mask_ff, wr_mask_in;
   logic                drop_ff, drop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [7:0]          rd_data_ff;

   logic [7:0]          mem [DEPTH];

   logic [PAGE_W-1:0]    p0, p1;
   logic [COL_SUM_W-1:0] col;
   logic                 in_range;
   logic [AW-1:0]        addr;
   logic [BIT_W-1:0]     lo_bit, hi_bit;
   logic [7:0]           span, dots, mask;
   logic                 side_col;
   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_waddr;
   logic [7:0]           mem_wdata;

   assign p0 = cmd_ff.y0[Y_W-1:BIT_W];
   assign p1 = cmd_ff.y1[Y_W-1:BIT_W];

   // Byte addressed by the current column and page.
   assign col = COL_SUM_W'(cur_x_ff) + COL_SUM_W'(column_offset);
   assign in_range = (col < COL_SUM_W'(COLUMNS)) &&
                     (PAGE_CMP_W'(cur_p_ff) < PAGE_CMP_W'(PAGES));
   assign addr = AW'(32'(cur_p_ff) * COLUMNS + 32'(col));

   // Rows of the rectangle that fall into the current page.
   assign lo_bit = (cur_p_ff == p0) ? cmd_ff.y0[BIT_W-1:0] : BIT_W'(0);
   assign hi_bit = (cur_p_ff == p1) ? cmd_ff.y1[BIT_W-1:0] : BIT_W'(7);
   assign span   = (BYTE_ONES << lo_bit) & (BYTE_ONES >> (BIT_W'(7) - hi_bit));
   assign dots   = ((cur_p_ff == p0) ? (8'd1 << cmd_ff.y0[BIT_W-1:0]) : BYTE_ZERO) |
                   ((cur_p_ff == p1) ? (8'd1 << cmd_ff.y1[BIT_W-1:0]) : BYTE_ZERO);
   assign side_col = (cur_x_ff == cmd_ff.x0) || (cur_x_ff == cmd_ff.x1);
   assign mask     = (cmd_ff.op == OP_RECT || side_col) ? span : dots;

   assign mem_re = (state_ff == S_RECT) || (state_ff == S_READ);

   always_comb begin
      if (state_ff == S_CLEAR || state_ff == S_FILL) begin
         mem_we    = 1'b1;
         mem_waddr = fill_addr_ff;
         mem_wdata = (state_ff == S_FILL && cmd_ff.white) ? BYTE_ONES : BYTE_ZERO;
      end else begin
         mem_we    = wr_pend_ff;
         mem_waddr = wr_addr_ff;
         mem_wdata = cmd_ff.white ? (rd_data_ff | wr_mask_ff)
                                  : (rd_data_ff & ~wr_mask_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cur_x_in      = cur_x_ff;
      cur_p_in      = cur_p_ff;
      fill_addr_in  = fill_addr_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = addr;
      wr_mask_in    = mask;
      drop_in       = drop_ff;
      rsp_valid_in  = 1'b0;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      cmd_pop       = 1'b0;
      unique case (state_ff) inside
         S_CLEAR, S_FILL: begin
            if (fill_addr_ff == AW'(DEPTH-1)) begin
               fill_addr_in = '0;
               state_in     = (state_ff == S_CLEAR) ? S_IDLE : S_DONE;
            end else begin
               fill_addr_in = fill_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_head;
               cur_x_in = cmd_head.x0;
               cur_p_in = cmd_head.y0[Y_W-1:BIT_W];
               drop_in  = 1'b0;
               unique case (cmd_head.op) inside
                  OP_RECT, OP_OUTLINE: state_in = S_RECT;
                  OP_SCREEN:           state_in = S_FILL;
                  OP_READ:             state_in = S_READ;
                  default:             state_in = S_DONE;
               endcase
            end
         end
         S_RECT: begin
            // Issue a read this cycle; the write lands in the next cycle.
            if (mask != BYTE_ZERO) begin
               if (in_range) begin
                  wr_pend_in = 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
            end
            if (cur_p_ff == p1) begin
               cur_p_in = p0;
               if (cur_x_ff == cmd_ff.x1) begin
                  state_in = S_DONE;
               end else begin
                  cur_x_in = cur_x_ff + 1'b1;
               end
            end else begin
               cur_p_in = cur_p_ff + 1'b1;
            end
         end
         S_READ: begin
            drop_in  = ~in_range;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = (cmd_ff.op == OP_READ && !drop_ff) ? rd_data_ff : BYTE_ZERO;
            rsp_status_in = drop_ff;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         fill_addr_ff <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         drop_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_addr_ff <= fill_addr_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         drop_ff      <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cur_x_ff      <= cur_x_in;
      cur_p_ff      <= cur_p_in;
      wr_addr_ff    <= wr_addr_in;
      wr_mask_ff    <= wr_mask_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign back_stat.clearing = (state_ff == S_CLEAR);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_byte      = rsp_byte_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

@@ hdl/page_framebuffer_draw_engine.sv @@
// ----------------------------------------------------------------------------
// Page framebuffer draw engine
// Monochrome frame store in 8-row pages with pixel, rectangle fill, outline,
// screen fill and byte read commands.
//
//   channel   ports                                   handshake
//   request   req_type, req_x/y_first/second, colour  start high, busy low
//   result    rsp_read_byte, rsp_status               rsp_valid, one cycle
//   config    csr_column_offset                       csr_valid and csr_ready
//
// After reset a clearing pass writes zero to all COLUMNS*PAGES bytes, one per
// cycle, and busy stays high for that time. A rectangle visits one byte per
// cycle (columns times pages spanned), a screen fill writes all COLUMNS*PAGES
// bytes one per cycle; the single store write port sets this.
// Two words can wait in the command queue while the back end works.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_type,
   input  logic [6:0] req_x_first,
   input  logic [5:0] req_y_first,
   input  logic [6:0] req_x_second,
   input  logic [5:0] req_y_second,
   input  logic       req_colour,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_column_offset
);
   import pfde_pkg::*;

   logic [OFFSET_W-1:0] column_offset_ff;
   logic                push, pop, queue_full, queue_not_empty;
   cmd_type             front_cmd, head_cmd;
   back_stat_type       back_stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_offset_ff <= OFFSET_RESET;
      end else if (csr_valid && csr_ready) begin
         column_offset_ff <= csr_column_offset;
      end
   end

   pfde_front u_front (
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_x_first  (req_x_first),
      .req_y_first  (req_y_first),
      .req_x_second (req_x_second),
      .req_y_second (req_y_second),
      .req_colour   (req_colour),
      .queue_full   (queue_full),
      .back_stat    (back_stat),
      .push         (push),
      .cmd          (front_cmd)
   );

   pfde_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head_cmd)
   );

   pfde_back #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .column_offset (column_offset_ff),
      .cmd_valid     (queue_not_empty),
      .cmd_head      (head_cmd),
      .cmd_pop       (pop),
      .back_stat     (back_stat),
      .rsp_valid     (rsp_valid),
      .rsp_read_byte (rsp_read_byte),
      .rsp_status    (rsp_status)
   );

endmodule
